// ===== hw/rtl/itoar_pkg.sv =====
package itoar_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int MAX_BASE    = 36;
   localparam int MIN_BASE    = 2;
   localparam int DECIMAL     = 10;
   localparam int BASE_W      = 6;
   localparam int DIGIT_W     = 6;
   localparam int COUNT_W     = 6;
   localparam int STORE_DEPTH = VALUE_WIDTH;
   localparam int STORE_AW    = $clog2(STORE_DEPTH);
   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_A     = 8'h61;
   localparam logic [7:0] CHAR_MINUS = 8'h2d;

   localparam logic [0:0] ACT_SIGNED   = 1'b0;
   localparam logic [0:0] ACT_UNSIGNED = 1'b1;

   // classified request handed from the front end to the back end
   typedef struct packed {
      logic                      negative;
      logic [VALUE_WIDTH-1:0]    magnitude;
      logic [BASE_W-1:0]         base;
   } job_type;

   // queue occupancy seen by both ends
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // floor(2^32 / base), so that value * recip >> 32 is the quotient or one short
   function automatic logic [VALUE_WIDTH-1:0] recip(input logic [BASE_W-1:0] b);
      logic [VALUE_WIDTH-1:0] r;
      case (b)
         6'd2:    r = 32'd2147483648;
         6'd3:    r = 32'd1431655765;
         6'd4:    r = 32'd1073741824;
         6'd5:    r = 32'd858993459;
         6'd6:    r = 32'd715827882;
         6'd7:    r = 32'd613566756;
         6'd8:    r = 32'd536870912;
         6'd9:    r = 32'd477218588;
         6'd10:   r = 32'd429496729;
         6'd11:   r = 32'd390451572;
         6'd12:   r = 32'd357913941;
         6'd13:   r = 32'd330382099;
         6'd14:   r = 32'd306783378;
         6'd15:   r = 32'd286331153;
         6'd16:   r = 32'd268435456;
         6'd17:   r = 32'd252645135;
         6'd18:   r = 32'd238609294;
         6'd19:   r = 32'd226050910;
         6'd20:   r = 32'd214748364;
         6'd21:   r = 32'd204522252;
         6'd22:   r = 32'd195225786;
         6'd23:   r = 32'd186737708;
         6'd24:   r = 32'd178956970;
         6'd25:   r = 32'd171798691;
         6'd26:   r = 32'd165191049;
         6'd27:   r = 32'd159072862;
         6'd28:   r = 32'd153391689;
         6'd29:   r = 32'd148102320;
         6'd30:   r = 32'd143165576;
         6'd31:   r = 32'd138547332;
         6'd32:   r = 32'd134217728;
         6'd33:   r = 32'd130150524;
         6'd34:   r = 32'd126322567;
         6'd35:   r = 32'd122713351;
         6'd36:   r = 32'd119304647;
         default: r = 32'd2147483648;
      endcase
      return r;
   endfunction

endpackage

// ===== hw/rtl/itoar_front.sv =====
module itoar_front
   import itoar_pkg::*;
(
   input  logic [0:0]             req_action,
   input  logic [VALUE_WIDTH-1:0] req_value,
   input  logic [BASE_W-1:0]      req_base,
   output job_type                job
);

   logic [BASE_W-1:0] base_sat;
   logic              negative;

   // clamp the base into the supported range
   always_comb begin
      if (req_base < BASE_W'(MIN_BASE)) begin
         base_sat = BASE_W'(MIN_BASE);
      end else if (req_base > BASE_W'(MAX_BASE)) begin
         base_sat = BASE_W'(MAX_BASE);
      end else begin
         base_sat = req_base;
      end
   end

   // minus sign only for signed decimal; other bases take the raw bit pattern
   assign negative = (req_action == ACT_SIGNED) && (base_sat == BASE_W'(DECIMAL))
                     && req_value[VALUE_WIDTH-1];

   assign job.negative  = negative;
   assign job.magnitude = negative ? (~req_value + VALUE_WIDTH'(1)) : req_value;
   assign job.base      = base_sat;

endmodule

// ===== hw/rtl/itoar_queue.sv =====
module itoar_queue
   import itoar_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  job_type          push_job,
   input  logic             pop,
   output job_type          head_job,
   output queue_status_type status
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   job_type            slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]     fill_ff, fill_in;
   logic               do_push, do_pop;

   assign status.full  = (fill_ff == (PTR_W+1)'(QUEUE_DEPTH));
   assign status.empty = (fill_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_job     = slot_ff[rd_ptr_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + (PTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - (PTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== hw/rtl/itoar_back.sv =====
module itoar_back
   import itoar_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  job_type          head_job,
   input  queue_status_type q_status,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [7:0]       rsp_ascii_char,
   output logic             rsp_last,
   output logic [COUNT_W-1:0] rsp_char_count
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_MUL,
      S_CORR,
      S_EMIT
   } state_type;

   state_type              state_ff;
   logic [VALUE_WIDTH-1:0] quot_ff;
   logic [VALUE_WIDTH-1:0] recip_ff;
   logic [VALUE_WIDTH-1:0] qest_ff;
   logic [BASE_W-1:0]      base_ff;
   logic                   neg_ff;
   logic                   sign_ff;
   logic [COUNT_W-1:0]     count_ff;
   logic [COUNT_W-1:0]     emit_ff;
   logic [COUNT_W-1:0]     total_ff;
   logic [DIGIT_W-1:0]     store_ff [STORE_DEPTH];
   logic                   rsp_valid_ff;
   logic [7:0]             rsp_char_ff;
   logic                   rsp_last_ff;
   logic [COUNT_W-1:0]     rsp_count_ff;

   logic [2*VALUE_WIDTH-1:0]        full_prod;
   logic [VALUE_WIDTH+BASE_W-1:0]   back_prod;
   logic [VALUE_WIDTH-1:0]          rem_raw;
   logic [BASE_W:0]                 rem_small;
   logic                            fix;
   logic [DIGIT_W-1:0]              digit;
   logic [VALUE_WIDTH-1:0]          quot_next;
   logic [COUNT_W-1:0]              count_next;
   logic [DIGIT_W-1:0]              emit_digit;
   logic                            slot_free;

   function automatic logic [7:0] digit_char(input logic [DIGIT_W-1:0] d);
      logic [7:0] c;
      if (d < DIGIT_W'(DECIMAL)) begin
         c = CHAR_ZERO + 8'(d);
      end else begin
         c = CHAR_A + 8'(d - DIGIT_W'(DECIMAL));
      end
      return c;
   endfunction

   // quotient estimate from the reciprocal table
   assign full_prod = {{VALUE_WIDTH{1'b0}}, quot_ff} * {{VALUE_WIDTH{1'b0}}, recip_ff};

   // remainder and one-step correction of the estimate
   assign back_prod  = {{BASE_W{1'b0}}, qest_ff} * {{VALUE_WIDTH{1'b0}}, base_ff};
   assign rem_raw    = quot_ff - back_prod[VALUE_WIDTH-1:0];
   assign rem_small  = rem_raw[BASE_W:0];
   assign fix        = (rem_small >= {1'b0, base_ff});
   assign digit      = fix ? DIGIT_W'(rem_small - {1'b0, base_ff}) : DIGIT_W'(rem_small);
   assign quot_next  = qest_ff + VALUE_WIDTH'(fix);
   assign count_next = count_ff + COUNT_W'(1);

   assign emit_digit = store_ff[STORE_AW'(emit_ff - COUNT_W'(1))];
   assign slot_free  = !rsp_valid_ff || !rsp_stall;
   assign pop        = (state_ff == S_IDLE) && !q_status.empty;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ascii_char = rsp_char_ff;
   assign rsp_last       = rsp_last_ff;
   assign rsp_char_count = rsp_count_ff;

   // sequencer, digit store and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         sign_ff      <= 1'b0;
         neg_ff       <= 1'b0;
         count_ff     <= '0;
         emit_ff      <= '0;
      end else begin
         if (slot_free) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (!q_status.empty) begin
                  quot_ff  <= head_job.magnitude;
                  base_ff  <= head_job.base;
                  recip_ff <= recip(head_job.base);
                  neg_ff   <= head_job.negative;
                  count_ff <= '0;
                  state_ff <= S_MUL;
               end
            end
            S_MUL: begin
               qest_ff  <= full_prod[2*VALUE_WIDTH-1:VALUE_WIDTH];
               state_ff <= S_CORR;
            end
            S_CORR: begin
               store_ff[count_ff[STORE_AW-1:0]] <= digit;
               count_ff <= count_next;
               quot_ff  <= quot_next;
               if (quot_next == '0) begin
                  emit_ff  <= count_next;
                  total_ff <= count_next + COUNT_W'(neg_ff);
                  sign_ff  <= neg_ff;
                  state_ff <= S_EMIT;
               end else begin
                  state_ff <= S_MUL;
               end
            end
            S_EMIT: begin
               if (slot_free) begin
                  rsp_valid_ff <= 1'b1;
                  if (sign_ff) begin
                     rsp_char_ff  <= CHAR_MINUS;
                     rsp_last_ff  <= 1'b0;
                     rsp_count_ff <= '0;
                     sign_ff      <= 1'b0;
                  end else begin
                     rsp_char_ff  <= digit_char(emit_digit);
                     rsp_last_ff  <= (emit_ff == COUNT_W'(1));
                     rsp_count_ff <= (emit_ff == COUNT_W'(1)) ? total_ff : '0;
                     emit_ff      <= emit_ff - COUNT_W'(1);
                     if (emit_ff == COUNT_W'(1)) begin
                        state_ff <= S_IDLE;
                     end
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // the corrected remainder is a proper digit of the base
   a_digit_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CORR) |-> (digit < base_ff))
      else $error("remainder not below base after correction");

   // never more digits than the store holds
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CORR) |-> (count_ff < COUNT_W'(STORE_DEPTH)))
      else $error("digit store overrun");

   // a minus sign belongs to decimal only
   a_sign_decimal: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) && neg_ff |-> (base_ff == BASE_W'(DECIMAL)))
      else $error("minus sign on non-decimal conversion");

   // the closing character carries a non-zero count
   a_last_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_last_ff |-> (rsp_count_ff != '0))
      else $error("last character without count");

endmodule

// ===== hw/rtl/integer_to_ascii_radix.sv =====
// Integer to ASCII converter, bases 2 to 36. Each request carries a 32-bit value, a
// signed/unsigned action and a base (clamped to 2..36); the block answers with one
// character per response, most significant digit first, '0'-'9' then 'a'-'z', with a
// leading '-' only for negative signed decimal values (other bases print the raw bit
// pattern). The final character has last set and the total character count. A front
// end classifies requests into a two-entry queue, so up to two further requests are
// taken while a conversion runs. The back end takes a request, then produces one digit at a
// time by a reciprocal multiply and then a remainder correction, then issues one character
// per cycle while the response side does not stall.
module integer_to_ascii_radix
   import itoar_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [0:0]             req_action,
   input  logic [VALUE_WIDTH-1:0] req_value,
   input  logic [BASE_W-1:0]      req_base,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [7:0]             rsp_ascii_char,
   output logic                   rsp_last,
   output logic [COUNT_W-1:0]     rsp_char_count
);

   job_type          front_job;
   job_type          head_job;
   queue_status_type q_status;
   logic             pop;

   // request classification
   itoar_front u_front (
      .req_action (req_action),
      .req_value  (req_value),
      .req_base   (req_base),
      .job        (front_job)
   );

   // queue between front and back end
   itoar_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (req_valid),
      .push_job (front_job),
      .pop      (pop),
      .head_job (head_job),
      .status   (q_status)
   );

   assign req_stall = q_status.full;

   // digit generation and character output
   itoar_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_job       (head_job),
      .q_status       (q_status),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_ascii_char (rsp_ascii_char),
      .rsp_last       (rsp_last),
      .rsp_char_count (rsp_char_count)
   );

endmodule

// ===== tb/tb_integer_to_ascii_radix.sv =====
`timescale 1ns / 1ps

module tb_integer_to_ascii_radix;
   import itoar_pkg::*;

   localparam int RANDOM_ITEMS = 350;
   localparam int IDLE_PCT     = 26;
   localparam int QUIET_FROM   = 3000;
   localparam int QUIET_TO     = 6000;
   localparam int HOLD_AT      = 1500;
   localparam int HOLD_LEN     = 400;
   localparam int DRAIN_CYCLES = 200;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int REPORT_MAX   = 10;

   typedef struct {
      logic [0:0]             action;
      logic [VALUE_WIDTH-1:0] value;
      logic [BASE_W-1:0]      base;
   } conv_req_type;

   typedef struct packed {
      logic [7:0]         ch;
      logic               last;
      logic [COUNT_W-1:0] count;
   } char_rsp_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [0:0]             req_action = ACT_SIGNED;
   logic [VALUE_WIDTH-1:0] req_value = '0;
   logic [BASE_W-1:0]      req_base = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [7:0]             rsp_ascii_char;
   logic                   rsp_last;
   logic [COUNT_W-1:0]     rsp_char_count;

   conv_req_type pending_reqs[$];
   char_rsp_type expected_chars[$];
   logic      req_taken = 1'b0;
   int        cycle_count = 0;
   int        hold_left = 0;
   int        error_count = 0;
   logic      quiet_window;

   integer_to_ascii_radix uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_value      (req_value),
      .req_base       (req_base),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_ascii_char (rsp_ascii_char),
      .rsp_last       (rsp_last),
      .rsp_char_count (rsp_char_count)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   assign quiet_window = (cycle_count >= QUIET_FROM) && (cycle_count < QUIET_TO);

   // expected characters of one conversion, most significant first
   function automatic void predict_chars(input logic [0:0] act,
                                         input logic [VALUE_WIDTH-1:0] val,
                                         input logic [BASE_W-1:0] b);
      logic [VALUE_WIDTH-1:0] mag;
      logic [DIGIT_W-1:0]     digits[STORE_DEPTH];
      int unsigned            radix;
      logic                   neg;
      int                     n;
      int                     total;
      char_rsp_type           r;
      radix = 32'(b);
      if (radix < MIN_BASE) radix = MIN_BASE;
      if (radix > MAX_BASE) radix = MAX_BASE;
      // minus sign only for signed decimal, otherwise the raw bit pattern
      neg = (act == ACT_SIGNED) && (radix == DECIMAL) && val[VALUE_WIDTH-1];
      mag = neg ? (~val + 1'b1) : val;
      n = 0;
      if (mag == 0) begin
         digits[0] = '0;
         n = 1;
      end else begin
         while (mag != 0) begin
            digits[n] = DIGIT_W'(mag % radix);
            mag = mag / radix;
            n++;
         end
      end
      total = n + (neg ? 1 : 0);
      if (neg) begin
         r.ch = CHAR_MINUS;
         r.last = 1'b0;
         r.count = '0;
         expected_chars.push_back(r);
      end
      for (int k = n - 1; k >= 0; k--) begin
         r.ch = (digits[k] < DECIMAL) ? CHAR_ZERO + 8'(digits[k])
                                      : CHAR_A + 8'(digits[k]) - 8'(DECIMAL);
         r.last = (k == 0);
         r.count = (k == 0) ? COUNT_W'(total) : '0;
         expected_chars.push_back(r);
      end
   endfunction

   function automatic void add_req(input logic [0:0] act,
                                   input logic [VALUE_WIDTH-1:0] val,
                                   input logic [BASE_W-1:0] b);
      conv_req_type item;
      item.action = act;
      item.value = val;
      item.base = b;
      pending_reqs.push_back(item);
   endfunction

   // cycle counter and watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_integer_to_ascii_radix: errors");
         $finish;
      end
   end

   // request driver
   always @(negedge clock) begin
      conv_req_type item;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_reqs.size() != 0 &&
             (quiet_window || $urandom_range(99) >= IDLE_PCT)) begin
            item = pending_reqs.pop_front();
            req_action <= item.action;
            req_value <= item.value;
            req_base <= item.base;
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // long response hold-off so the block backs up into its request side
   always @(negedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (cycle_count == HOLD_AT) begin
         hold_left <= HOLD_LEN;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // response stall
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= (hold_left != 0) ||
                      (!quiet_window && $urandom_range(99) < IDLE_PCT);
      end
   end

   // monitor: predict on accepted requests, check accepted responses
   always @(posedge clock) begin : rsp_monitor
      char_rsp_type want;
      req_taken <= !reset && req_valid && !req_stall;
      if (!reset && req_valid && !req_stall) begin
         predict_chars(req_action, req_value, req_base);
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_chars.size() == 0) begin
            if (error_count < REPORT_MAX) begin
               $display("unexpected response: char %h last %b count %0d",
                        rsp_ascii_char, rsp_last, rsp_char_count);
            end
            error_count++;
         end else begin
            want = expected_chars.pop_front();
            if (rsp_ascii_char !== want.ch || rsp_last !== want.last ||
                rsp_char_count !== want.count) begin
               if (error_count < REPORT_MAX) begin
                  $display("mismatch: expected %h/%b/%0d got %h/%b/%0d",
                           want.ch, want.last, want.count,
                           rsp_ascii_char, rsp_last, rsp_char_count);
               end
               error_count++;
            end
         end
      end
   end

   // stimulus and end of run
   initial begin
      int sel;
      logic [0:0] act;
      logic [VALUE_WIDTH-1:0] val;
      logic [BASE_W-1:0] b;

      // directed: zero, extremes, sign handling, base saturation
      add_req(ACT_SIGNED, 32'd0, 6'd10);
      add_req(ACT_UNSIGNED, 32'd0, 6'd2);
      add_req(ACT_UNSIGNED, 32'd0, 6'd36);
      add_req(ACT_UNSIGNED, 32'hffffffff, 6'd2);
      add_req(ACT_UNSIGNED, 32'hffffffff, 6'd10);
      add_req(ACT_UNSIGNED, 32'hffffffff, 6'd36);
      add_req(ACT_SIGNED, 32'hffffffff, 6'd10);
      add_req(ACT_SIGNED, 32'hffffffff, 6'd16);
      add_req(ACT_SIGNED, 32'hffffffff, 6'd2);
      add_req(ACT_SIGNED, 32'h80000000, 6'd10);
      add_req(ACT_UNSIGNED, 32'h80000000, 6'd10);
      add_req(ACT_SIGNED, 32'h80000000, 6'd8);
      add_req(ACT_SIGNED, 32'h7fffffff, 6'd10);
      add_req(ACT_SIGNED, 32'd12345, 6'd10);
      add_req(ACT_UNSIGNED, 32'd35, 6'd36);
      add_req(ACT_UNSIGNED, 32'd255, 6'd16);
      add_req(ACT_SIGNED, 32'd5, 6'd0);
      add_req(ACT_UNSIGNED, 32'd5, 6'd1);
      add_req(ACT_UNSIGNED, 32'd1295, 6'd37);
      add_req(ACT_SIGNED, 32'hffffff85, 6'd63);
      add_req(ACT_UNSIGNED, 32'h0000002a, 6'd42);
      add_req(ACT_SIGNED, 32'hfffffff6, 6'd10);

      // random: mostly legal bases with a bias to decimal, some out of range
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         act = 1'($urandom_range(1));
         sel = $urandom_range(99);
         if (sel < 12) b = BASE_W'($urandom_range(63));
         else if (sel < 45) b = BASE_W'(DECIMAL);
         else b = BASE_W'($urandom_range(MAX_BASE, MIN_BASE));
         sel = $urandom_range(99);
         if (sel < 30) val = $urandom;
         else if (sel < 48) val = $urandom_range(1000);
         else if (sel < 60) val = 32'h80000000 ^ $urandom_range(15);
         else if (sel < 72) val = 32'hffffffff - $urandom_range(100);
         else if (sel < 82) val = 32'd1 << $urandom_range(31);
         else val = $urandom >> $urandom_range(31);
         add_req(act, val, b);
      end

      repeat (9) @(negedge clock);
      reset <= 1'b0;

      while (pending_reqs.size() != 0 || req_valid) @(negedge clock);
      while (expected_chars.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (error_count == 0 && expected_chars.size() == 0) begin
         $display("tb_integer_to_ascii_radix: clean");
      end else begin
         $display("tb_integer_to_ascii_radix: errors");
      end
      $finish;
   end

endmodule
